>>> rtl/jtl_pkg.sv
package jtl_pkg;

   // one byte of text
   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   // one token event
   typedef struct packed {
      logic [3:0]  kind;
      logic [7:0]  out_char;
      logic [15:0] line_number;
      logic        out_last;
   } rsp_type;

   localparam int MAX_RESULTS = 4;
   localparam int SLOT_BITS   = $clog2(MAX_RESULTS);
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);

   // all events caused by one byte
   typedef struct packed {
      logic [SLOT_BITS:0]                count;
      rsp_type [MAX_RESULTS-1:0]         slot;
   } bundle_type;

   localparam logic [3:0] KIND_LCURLY     = 4'd0;
   localparam logic [3:0] KIND_RCURLY     = 4'd1;
   localparam logic [3:0] KIND_LBRACK     = 4'd2;
   localparam logic [3:0] KIND_RBRACK     = 4'd3;
   localparam logic [3:0] KIND_COLON      = 4'd4;
   localparam logic [3:0] KIND_COMMA      = 4'd5;
   localparam logic [3:0] KIND_STR_CHAR   = 4'd6;
   localparam logic [3:0] KIND_STR_END    = 4'd7;
   localparam logic [3:0] KIND_NUM_CHAR   = 4'd8;
   localparam logic [3:0] KIND_NUM_END    = 4'd9;
   localparam logic [3:0] KIND_TRUE       = 4'd10;
   localparam logic [3:0] KIND_FALSE      = 4'd11;
   localparam logic [3:0] KIND_NULL       = 4'd12;
   localparam logic [3:0] KIND_INVALID    = 4'd13;
   localparam logic [3:0] KIND_UNID       = 4'd14;
   localparam logic [3:0] KIND_EOF        = 4'd15;

   localparam logic [7:0] CHAR_TAB      = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;
   localparam logic [7:0] CHAR_CR       = 8'h0D;
   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_QUOTE    = 8'h22;
   localparam logic [7:0] CHAR_APOS     = 8'h27;
   localparam logic [7:0] CHAR_COMMA    = 8'h2C;
   localparam logic [7:0] CHAR_MINUS    = 8'h2D;
   localparam logic [7:0] CHAR_DOT      = 8'h2E;
   localparam logic [7:0] CHAR_COLON    = 8'h3A;
   localparam logic [7:0] CHAR_QUESTION = 8'h3F;
   localparam logic [7:0] CHAR_LBRACK   = 8'h5B;
   localparam logic [7:0] CHAR_BSLASH   = 8'h5C;
   localparam logic [7:0] CHAR_RBRACK   = 8'h5D;
   localparam logic [7:0] CHAR_LCURLY   = 8'h7B;
   localparam logic [7:0] CHAR_RCURLY   = 8'h7D;
   localparam logic [7:0] CHAR_NONE     = 8'h00;

   localparam logic [2:0] CAND_ALL = 3'b111;
   localparam logic [2:0] POS_MAX  = 3'd7;

   typedef enum logic [6:0] {
      MODE_IDLE = 7'b0000001,
      MODE_STR  = 7'b0000010,
      MODE_ESC  = 7'b0000100,
      MODE_INT  = 7'b0001000,
      MODE_DOT  = 7'b0010000,
      MODE_FRAC = 7'b0100000,
      MODE_WORD = 7'b1000000
   } mode_type;

   function automatic logic is_digit(logic [7:0] b);
      return (b >= 8'h30) && (b <= 8'h39);
   endfunction

   function automatic logic is_alpha(logic [7:0] b);
      return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
   endfunction

   function automatic logic [7:0] unescape(logic [7:0] b);
      logic [7:0] r;
      if (b == 8'h6E) begin
         r = CHAR_NEWLINE;
      end else if (b == CHAR_APOS || b == CHAR_BSLASH || b == CHAR_QUOTE) begin
         r = b;
      end else begin
         r = CHAR_QUESTION;
      end
      return r;
   endfunction

   // keyword letters: bit 8 flags a letter present at that position
   function automatic logic [8:0] kw_char(logic [1:0] kw, logic [2:0] pos);
      logic [8:0] r;
      r = 9'h000;
      case (kw)
         2'd0: begin
            case (pos)
               3'd0: r = {1'b1, 8'h74};
               3'd1: r = {1'b1, 8'h72};
               3'd2: r = {1'b1, 8'h75};
               3'd3: r = {1'b1, 8'h65};
               default: r = 9'h000;
            endcase
         end
         2'd1: begin
            case (pos)
               3'd0: r = {1'b1, 8'h66};
               3'd1: r = {1'b1, 8'h61};
               3'd2: r = {1'b1, 8'h6C};
               3'd3: r = {1'b1, 8'h73};
               3'd4: r = {1'b1, 8'h65};
               default: r = 9'h000;
            endcase
         end
         2'd2: begin
            case (pos)
               3'd0: r = {1'b1, 8'h6E};
               3'd1: r = {1'b1, 8'h75};
               3'd2: r = {1'b1, 8'h6C};
               3'd3: r = {1'b1, 8'h6C};
               default: r = 9'h000;
            endcase
         end
         default: r = 9'h000;
      endcase
      return r;
   endfunction

   // returns {candidates, position} after one more word character
   function automatic logic [5:0] word_take(logic [2:0] cand, logic [2:0] pos,
                                            logic [7:0] b);
      logic [2:0] c;
      logic [8:0] k;
      c = cand;
      for (int i = 0; i < 3; i++) begin
         k = kw_char(2'(i), pos);
         if (!k[8] || (k[7:0] != b)) begin
            c[i] = 1'b0;
         end
      end
      return {c, (pos != POS_MAX) ? pos + 3'd1 : pos};
   endfunction

   function automatic logic [3:0] word_kind(logic [2:0] cand, logic [2:0] pos);
      logic [3:0] k;
      if (cand[0] && pos == 3'd4) begin
         k = KIND_TRUE;
      end else if (cand[1] && pos == 3'd5) begin
         k = KIND_FALSE;
      end else if (cand[2] && pos == 3'd4) begin
         k = KIND_NULL;
      end else begin
         k = KIND_INVALID;
      end
      return k;
   endfunction

   function automatic bundle_type push(bundle_type bd, logic [3:0] kind,
                                       logic [7:0] ch, logic [15:0] line);
      bundle_type r;
      r = bd;
      if (r.count < (SLOT_BITS+1)'(MAX_RESULTS)) begin
         r.slot[r.count[SLOT_BITS-1:0]] = '{kind: kind, out_char: ch,
                                            line_number: line, out_last: 1'b0};
         r.count = r.count + 1'b1;
      end
      return r;
   endfunction

endpackage

>>> rtl/json_token_lexer.sv
// streaming json lexer: takes one byte of text per beat on req_ and gives token events on
// rsp_, each stamped with the current line number (low 16 bits of a saturating counter
// of LINE_BITS bits, starting at one). a byte may cause zero to four events; the last
// event of a byte carries out_last, and the final byte of a text (in_last) closes any
// open token, gives eof and returns all state to its reset values. a byte is taken every
// cycle while the four-entry queue of event groups has room; the output side drains one
// event per cycle while rsp_ready is high, so the sustained rate is one byte per cycle as long
// as the text averages at most one event per byte, and bursts of several events per byte are
// absorbed by the queue. the events of an accepted byte are written into the queue at the
// accepting edge and loaded into the output register once that register is free or drained.
// string bodies arrive unescaped, number lexemes character by character; true, false and
// null are matched, any other word is flagged invalid.
module json_token_lexer #(
   parameter int LINE_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  jtl_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output jtl_pkg::rsp_type  rsp_data
);

   jtl_pkg::bundle_type  fe_bundle;
   jtl_pkg::bundle_type  q_head;
   logic                 fe_push;
   logic                 q_full;
   logic                 q_empty;
   logic                 be_pop;
   logic                 req_fire;

   // a byte enters whenever the queue can hold its events
   assign req_ready = !q_full;
   assign req_fire  = req_valid && req_ready;

   // front: lexer state machine, classifies one byte into an event group per cycle while the queue has room
   jtl_front #(
      .LINE_BITS (LINE_BITS)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .fire   (req_fire),
      .req    (req_data),
      .push   (fe_push),
      .bundle (fe_bundle)
   );

   // event groups wait here; bytes that give no event skip it
   jtl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fe_push),
      .push_data (fe_bundle),
      .pop       (be_pop),
      .head      (q_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   // back: unrolls each group into single beats through the output register
   jtl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .empty     (q_empty),
      .pop       (be_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> rtl/jtl_front.sv
module jtl_front #(
   parameter int LINE_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  jtl_pkg::req_type     req,
   output logic                 push,
   output jtl_pkg::bundle_type  bundle
);

   jtl_pkg::mode_type      mode_ff, mode_in;
   logic [2:0]             cand_ff, cand_in;
   logic [2:0]             pos_ff, pos_in;
   logic [LINE_BITS-1:0]   line_ff, line_in, line_inc;
   logic [LINE_BITS+15:0]  old_ext, new_ext;
   logic [15:0]            old16, new16;

   // saturating line counter, shown as its low 16 bits
   assign line_inc = (&line_ff) ? line_ff : line_ff + LINE_BITS'(1);
   assign old_ext  = {16'h0000, line_ff};
   assign new_ext  = {16'h0000, line_inc};
   assign old16    = old_ext[15:0];
   assign new16    = new_ext[15:0];

   always_comb begin
      logic [7:0]          b;
      logic                last;
      logic                bumped;
      logic                rescan;
      logic [15:0]         cur;
      jtl_pkg::mode_type   mode_v;
      logic [2:0]          cand_v;
      logic [2:0]          pos_v;
      jtl_pkg::bundle_type bd;

      b      = req.in_byte;
      last   = req.in_last;
      bumped = 1'b0;
      rescan = 1'b0;
      cur    = old16;
      mode_v = mode_ff;
      cand_v = cand_ff;
      pos_v  = pos_ff;
      bd     = '0;

      case (mode_ff)
         jtl_pkg::MODE_STR: begin
            if (b == jtl_pkg::CHAR_NEWLINE) begin
               bumped = 1'b1;
               cur    = new16;
            end
            if (b == jtl_pkg::CHAR_BSLASH) begin
               mode_v = jtl_pkg::MODE_ESC;
            end else if (b == jtl_pkg::CHAR_QUOTE) begin
               bd     = jtl_pkg::push(bd, jtl_pkg::KIND_STR_END, jtl_pkg::CHAR_NONE, cur);
               mode_v = jtl_pkg::MODE_IDLE;
            end else begin
               bd = jtl_pkg::push(bd, jtl_pkg::KIND_STR_CHAR, b, cur);
            end
         end
         jtl_pkg::MODE_ESC: begin
            if (b == jtl_pkg::CHAR_NEWLINE) begin
               bumped = 1'b1;
               cur    = new16;
            end
            bd     = jtl_pkg::push(bd, jtl_pkg::KIND_STR_CHAR, jtl_pkg::unescape(b), cur);
            mode_v = jtl_pkg::MODE_STR;
         end
         jtl_pkg::MODE_INT: begin
            if (jtl_pkg::is_digit(b)) begin
               bd = jtl_pkg::push(bd, jtl_pkg::KIND_NUM_CHAR, b, cur);
            end else if (b == jtl_pkg::CHAR_DOT) begin
               mode_v = jtl_pkg::MODE_DOT;
            end else begin
               bd     = jtl_pkg::push(bd, jtl_pkg::KIND_NUM_END, jtl_pkg::CHAR_NONE, cur);
               mode_v = jtl_pkg::MODE_IDLE;
               rescan = 1'b1;
            end
         end
         jtl_pkg::MODE_DOT: begin
            if (jtl_pkg::is_digit(b)) begin
               bd     = jtl_pkg::push(bd, jtl_pkg::KIND_NUM_CHAR, jtl_pkg::CHAR_DOT, cur);
               bd     = jtl_pkg::push(bd, jtl_pkg::KIND_NUM_CHAR, b, cur);
               mode_v = jtl_pkg::MODE_FRAC;
            end else begin
               bd     = jtl_pkg::push(bd, jtl_pkg::KIND_NUM_END, jtl_pkg::CHAR_NONE, cur);
               bd     = jtl_pkg::push(bd, jtl_pkg::KIND_UNID, jtl_pkg::CHAR_NONE, cur);
               mode_v = jtl_pkg::MODE_IDLE;
               // final minus after a held dot is reported as a stray char
               if (last && b == jtl_pkg::CHAR_MINUS) begin
                  bd = jtl_pkg::push(bd, jtl_pkg::KIND_UNID, jtl_pkg::CHAR_NONE, cur);
               end else begin
                  rescan = 1'b1;
               end
            end
         end
         jtl_pkg::MODE_FRAC: begin
            if (jtl_pkg::is_digit(b)) begin
               bd = jtl_pkg::push(bd, jtl_pkg::KIND_NUM_CHAR, b, cur);
            end else begin
               bd     = jtl_pkg::push(bd, jtl_pkg::KIND_NUM_END, jtl_pkg::CHAR_NONE, cur);
               mode_v = jtl_pkg::MODE_IDLE;
               rescan = 1'b1;
            end
         end
         jtl_pkg::MODE_WORD: begin
            if (jtl_pkg::is_alpha(b) || jtl_pkg::is_digit(b)) begin
               {cand_v, pos_v} = jtl_pkg::word_take(cand_v, pos_v, b);
            end else begin
               bd     = jtl_pkg::push(bd, jtl_pkg::word_kind(cand_v, pos_v),
                                      jtl_pkg::CHAR_NONE, cur);
               cand_v = jtl_pkg::CAND_ALL;
               pos_v  = 3'd0;
               mode_v = jtl_pkg::MODE_IDLE;
               rescan = 1'b1;
            end
         end
         default: begin
            mode_v = jtl_pkg::MODE_IDLE;
            rescan = 1'b1;
         end
      endcase

      if (rescan) begin
         case (b)
            jtl_pkg::CHAR_LCURLY:
               bd = jtl_pkg::push(bd, jtl_pkg::KIND_LCURLY, jtl_pkg::CHAR_NONE, cur);
            jtl_pkg::CHAR_RCURLY:
               bd = jtl_pkg::push(bd, jtl_pkg::KIND_RCURLY, jtl_pkg::CHAR_NONE, cur);
            jtl_pkg::CHAR_LBRACK:
               bd = jtl_pkg::push(bd, jtl_pkg::KIND_LBRACK, jtl_pkg::CHAR_NONE, cur);
            jtl_pkg::CHAR_RBRACK:
               bd = jtl_pkg::push(bd, jtl_pkg::KIND_RBRACK, jtl_pkg::CHAR_NONE, cur);
            jtl_pkg::CHAR_COLON:
               bd = jtl_pkg::push(bd, jtl_pkg::KIND_COLON, jtl_pkg::CHAR_NONE, cur);
            jtl_pkg::CHAR_COMMA:
               bd = jtl_pkg::push(bd, jtl_pkg::KIND_COMMA, jtl_pkg::CHAR_NONE, cur);
            jtl_pkg::CHAR_NEWLINE: begin
               bumped = 1'b1;
               cur    = new16;
            end
            jtl_pkg::CHAR_QUOTE:
               mode_v = jtl_pkg::MODE_STR;
            jtl_pkg::CHAR_SPACE, jtl_pkg::CHAR_CR, jtl_pkg::CHAR_TAB: begin
            end
            default: begin
               if (jtl_pkg::is_digit(b) || b == jtl_pkg::CHAR_MINUS) begin
                  bd     = jtl_pkg::push(bd, jtl_pkg::KIND_NUM_CHAR, b, cur);
                  mode_v = jtl_pkg::MODE_INT;
               end else if (jtl_pkg::is_alpha(b)) begin
                  {cand_v, pos_v} = jtl_pkg::word_take(jtl_pkg::CAND_ALL, 3'd0, b);
                  mode_v          = jtl_pkg::MODE_WORD;
               end else begin
                  bd = jtl_pkg::push(bd, jtl_pkg::KIND_UNID, jtl_pkg::CHAR_NONE, cur);
               end
            end
         endcase
      end

      // end of text: close whatever is open, then eof
      if (last) begin
         case (mode_v)
            jtl_pkg::MODE_STR, jtl_pkg::MODE_ESC:
               bd = jtl_pkg::push(bd, jtl_pkg::KIND_STR_END, jtl_pkg::CHAR_NONE, cur);
            jtl_pkg::MODE_INT, jtl_pkg::MODE_FRAC:
               bd = jtl_pkg::push(bd, jtl_pkg::KIND_NUM_END, jtl_pkg::CHAR_NONE, cur);
            jtl_pkg::MODE_DOT: begin
               bd = jtl_pkg::push(bd, jtl_pkg::KIND_NUM_END, jtl_pkg::CHAR_NONE, cur);
               bd = jtl_pkg::push(bd, jtl_pkg::KIND_UNID, jtl_pkg::CHAR_NONE, cur);
            end
            jtl_pkg::MODE_WORD:
               bd = jtl_pkg::push(bd, jtl_pkg::word_kind(cand_v, pos_v),
                                  jtl_pkg::CHAR_NONE, cur);
            default: begin
            end
         endcase
         bd = jtl_pkg::push(bd, jtl_pkg::KIND_EOF, jtl_pkg::CHAR_NONE, cur);
      end

      if (bd.count != '0) begin
         bd.slot[jtl_pkg::SLOT_BITS'(bd.count - 1'b1)].out_last = 1'b1;
      end

      if (last) begin
         mode_in = jtl_pkg::MODE_IDLE;
         cand_in = jtl_pkg::CAND_ALL;
         pos_in  = 3'd0;
         line_in = LINE_BITS'(1);
      end else begin
         mode_in = mode_v;
         cand_in = cand_v;
         pos_in  = pos_v;
         line_in = bumped ? line_inc : line_ff;
      end
      bundle = bd;
   end

   assign push = fire && (bundle.count != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= jtl_pkg::MODE_IDLE;
         cand_ff <= jtl_pkg::CAND_ALL;
         pos_ff  <= 3'd0;
         line_ff <= LINE_BITS'(1);
      end else if (fire) begin
         mode_ff <= mode_in;
         cand_ff <= cand_in;
         pos_ff  <= pos_in;
         line_ff <= line_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      push |-> bundle.count <= (jtl_pkg::SLOT_BITS+1)'(jtl_pkg::MAX_RESULTS))
      else $error("more events than slots");
   a_last_resets: assert property (@(posedge clock) disable iff (reset)
      fire && req.in_last |=> mode_ff == jtl_pkg::MODE_IDLE && line_ff == LINE_BITS'(1))
      else $error("state not cleared after final byte");
   a_last_eof: assert property (@(posedge clock) disable iff (reset)
      fire && req.in_last |-> push)
      else $error("final byte gave no eof");
`endif

endmodule

>>> rtl/jtl_queue.sv
module jtl_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  jtl_pkg::bundle_type  push_data,
   input  logic                 pop,
   output jtl_pkg::bundle_type  head,
   output logic                 full,
   output logic                 empty
);

   jtl_pkg::bundle_type                 entry_ff [jtl_pkg::QUEUE_DEPTH];
   logic [jtl_pkg::PTR_BITS-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [jtl_pkg::PTR_BITS-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [jtl_pkg::PTR_BITS:0]          count_ff, count_in;

   assign full  = count_ff == (jtl_pkg::PTR_BITS+1)'(jtl_pkg::QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push || pop)
      else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("pop from empty queue");
`endif

endmodule

>>> rtl/jtl_back.sv
module jtl_back (
   input  logic                 clock,
   input  logic                 reset,
   input  jtl_pkg::bundle_type  head,
   input  logic                 empty,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output jtl_pkg::rsp_type     rsp_data
);

   logic                             valid_ff, valid_in;
   jtl_pkg::rsp_type                 data_ff, data_in;
   logic [jtl_pkg::SLOT_BITS-1:0]    idx_ff, idx_in;
   logic                             load;
   logic                             last_slot;

   assign load      = (!valid_ff || rsp_ready) && !empty;
   assign last_slot = idx_ff == jtl_pkg::SLOT_BITS'(head.count - 1'b1);
   assign pop       = load && last_slot;

   always_comb begin
      data_in  = data_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff && !rsp_ready;
      if (load) begin
         data_in  = head.slot[idx_ff];
         valid_in = 1'b1;
         idx_in   = last_slot ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule
